// ===== rtl/core/bar_pkg.sv =====
// shared constants and types for the button auto-repeat core
`default_nettype none

package bar_pkg;

  // button and time geometry
  localparam int NumButtons = 16;
  localparam int TimeW      = 32;
  localparam int MaskW      = 16;
  localparam int DelayW     = 16;
  localparam int IndexW     = 8;

  // stream payload widths, padded to whole bytes
  localparam int InFieldsW  = TimeW + MaskW + 1;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = 5 * MaskW + 1;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // register reset values
  localparam logic [DelayW-1:0] InitialDelayRst  = DelayW'(170);
  localparam logic [DelayW-1:0] RepeatIntervalRst = DelayW'(50);

  // register indexes
  localparam logic [IndexW-1:0] RegInitialDelay  = IndexW'(0);
  localparam logic [IndexW-1:0] RegRepeatInterval = IndexW'(1);

  // time value a released button holds
  localparam logic [TimeW-1:0] TimeIdle = '1;

  // control from the top level to every button lane
  typedef struct packed {
    logic advance;
    logic clear;
  } lane_ctl_t;

  // timing registers seen by the lanes
  typedef struct packed {
    logic [DelayW-1:0] initial_delay_ms;
    logic [DelayW-1:0] repeat_interval_ms;
  } timing_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bar_cfg.sv =====
// configuration registers: initial delay and repeat interval
`default_nettype none

module bar_cfg (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [bar_pkg::IndexW-1:0]    cfg_index,
  input  wire  [bar_pkg::DelayW-1:0]    cfg_data,
  output bar_pkg::timing_cfg_t          timing
);

  // writes are always accepted
  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.initial_delay_ms   <= bar_pkg::InitialDelayRst;
      timing.repeat_interval_ms <= bar_pkg::RepeatIntervalRst;
    end else if (cfg_valid) begin
      if (cfg_index == bar_pkg::RegInitialDelay) begin
        timing.initial_delay_ms <= cfg_data;
      end else if (cfg_index == bar_pkg::RegRepeatInterval) begin
        timing.repeat_interval_ms <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bar_lane.sv =====
// one button lane: press start and last repeat timestamps plus repeat decision
`default_nettype none

module bar_lane (
  input  wire                          clk,
  input  wire                          rst,
  input  bar_pkg::lane_ctl_t           ctl,
  input  bar_pkg::timing_cfg_t         timing,
  input  wire  [bar_pkg::TimeW-1:0]    now_ms,
  input  wire                          is_down,
  input  wire                          was_down,
  output logic                         rep
);

  logic [bar_pkg::TimeW-1:0] press_start;
  logic [bar_pkg::TimeW-1:0] last_repeat;
  logic [bar_pkg::TimeW-1:0] held_for;
  logic [bar_pkg::TimeW-1:0] since;
  logic                      press_edge;
  logic                      delay_done;
  logic                      interval_done;
  logic                      fire;

  // elapsed times, modulo the time width
  assign held_for = now_ms - press_start;
  assign since    = now_ms - last_repeat;

  // repeat decision
  assign press_edge    = is_down & ~was_down;
  assign delay_done    = held_for >= bar_pkg::TimeW'(timing.initial_delay_ms);
  assign interval_done = (timing.repeat_interval_ms == '0) ||
                         (since >= bar_pkg::TimeW'(timing.repeat_interval_ms));
  assign fire          = is_down & was_down & delay_done & interval_done;
  assign rep           = press_edge | fire;

  // timestamp update
  always_ff @(posedge clk) begin
    if (rst) begin
      press_start <= bar_pkg::TimeIdle;
      last_repeat <= bar_pkg::TimeIdle;
    end else if (ctl.advance) begin
      if (ctl.clear) begin
        press_start <= bar_pkg::TimeIdle;
        last_repeat <= bar_pkg::TimeIdle;
      end else if (press_edge) begin
        press_start <= now_ms;
        last_repeat <= now_ms;
      end else if (!is_down) begin
        press_start <= bar_pkg::TimeIdle;
      end else if (fire) begin
        last_repeat <= now_ms;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/button_auto_repeat_core.sv =====
// top level of the button auto-repeat core
// an item passes through the input register and then the result register
// throughput: one poll item per cycle while the output is not stalled; all button lanes evaluate in parallel
// the input register is freed in the same cycle the result register takes its item
// reset: synchronous; delay 170 ms, interval 50 ms, last sample zero,
// all timestamps all ones, both stream stages empty
`default_nettype none

module button_auto_repeat_core (
  input  wire                              clk,
  input  wire                              rst,
  // poll items
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // now_ms[31:0], buttons_now[47:32], source_available[48], zero pad
  input  wire  [bar_pkg::InDataW-1:0]      s_tdata,
  // result items
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // pressed_mask[15:0], just_pressed_mask[31:16], just_released_mask[47:32],
  // held_mask[63:48], repeat_mask[79:64], any_pressed[80], zero pad
  output logic [bar_pkg::OutDataW-1:0]     m_tdata,
  // register writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bar_pkg::IndexW-1:0]       cfg_index,
  input  wire  [bar_pkg::DelayW-1:0]       cfg_data
);

  localparam int TW = bar_pkg::TimeW;
  localparam int MW = bar_pkg::MaskW;
  localparam int NB = bar_pkg::NumButtons;

  bar_pkg::timing_cfg_t timing;
  bar_pkg::lane_ctl_t   ctl;

  logic          in_valid;
  logic [TW-1:0] in_now;
  logic [MW-1:0] in_buttons;
  logic          in_avail;
  logic          advance;

  logic [MW-1:0] last_sample;
  logic [MW-1:0] cur;
  logic [MW-1:0] prev;
  logic [MW-1:0] rep;
  logic [MW-1:0] btn_mask;

  logic [bar_pkg::OutFieldsW-1:0] result_next;

  bar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // pipeline handshake
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now     <= s_tdata[TW-1:0];
      in_buttons <= s_tdata[TW+MW-1:TW];
      in_avail   <= s_tdata[TW+MW];
    end
  end

  // buttons beyond the lane count are ignored
  always_comb begin
    btn_mask = '0;
    for (int i = 0; i < NB; i++) begin
      btn_mask[i] = 1'b1;
    end
  end

  assign cur  = in_buttons & btn_mask;
  assign prev = last_sample;

  assign ctl.advance = advance;
  assign ctl.clear   = ~in_avail;

  // per-button lanes
  for (genvar g = 0; g < MW; g++) begin : g_lane
    if (g < NB) begin : g_on
      bar_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .timing   (timing),
        .now_ms   (in_now),
        .is_down  (cur[g]),
        .was_down (prev[g]),
        .rep      (rep[g])
      );
    end else begin : g_off
      assign rep[g] = 1'b0;
    end
  end

  // previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
    end else if (advance) begin
      last_sample <= in_avail ? cur : '0;
    end
  end

  // result fields; all zero when the source is gone
  always_comb begin
    if (in_avail) begin
      result_next = {(cur != '0), rep, cur & prev, ~cur & prev, cur & ~prev, cur};
    end else begin
      result_next = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= bar_pkg::OutDataW'(result_next);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bar_checker.sv =====
// port-level checks on the button auto-repeat core, bound to the top level
`default_nettype none

module bar_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire [bar_pkg::OutDataW-1:0]   m_tdata
);

  localparam int MW = bar_pkg::MaskW;

  logic [MW-1:0] pressed;
  logic [MW-1:0] just_pressed;
  logic [MW-1:0] just_released;
  logic [MW-1:0] held;
  logic [MW-1:0] repeats;
  logic          any_pressed;

  assign pressed       = m_tdata[MW-1:0];
  assign just_pressed  = m_tdata[2*MW-1:MW];
  assign just_released = m_tdata[3*MW-1:2*MW];
  assign held          = m_tdata[4*MW-1:3*MW];
  assign repeats       = m_tdata[5*MW-1:4*MW];
  assign any_pressed   = m_tdata[5*MW];

  // pressed buttons split into fresh presses and holds
  a_press_split: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((held | just_pressed) == pressed) && ((held & just_pressed) == '0))
    else $error("pressed mask does not split into held and just pressed");

  // a release is never reported for a button that is down
  a_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((just_released & pressed) == '0))
    else $error("released button still shown pressed");

  // every fresh press fires an event, and only down buttons fire
  a_repeat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((just_pressed & ~repeats) == '0) && ((repeats & ~pressed) == '0))
    else $error("repeat mask inconsistent with press masks");

  // summary flag follows the pressed mask
  a_any: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (any_pressed == (pressed != '0)))
    else $error("any_pressed disagrees with pressed mask");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind button_auto_repeat_core bar_checker u_bar_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
